// ===== hw/rtl/ddpm_pkg.sv =====
// shared types, widths and constants of the differential drive pid mixer
// no dependencies; imported by every module and interface of the block
`timescale 1ns / 1ps

package ddpm_pkg;

    // fixed field widths
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 8;

    // block constants
    localparam int INTEGRAL_WIDTH = 32;
    localparam int DUTY_LIMIT     = 255;
    localparam int TERM_SHIFT     = 40;
    localparam int FRAC_SHIFT     = 16;

    // register map
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = IDX_W + 2;
    localparam int DATA_W   = 32;

    localparam logic [IDX_W-1:0] REG_SPEED_SETPOINT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_OMEGA_SETPOINT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_SPEED_KP       = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPEED_KI       = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_SPEED_KD       = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_OMEGA_KP       = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_OMEGA_KI       = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_OMEGA_KD       = IDX_W'(7);

    localparam logic [GAIN_W-1:0] SPEED_KP_RST = GAIN_W'(128);
    localparam logic [GAIN_W-1:0] SPEED_KI_RST = GAIN_W'(45);
    localparam logic [GAIN_W-1:0] SPEED_KD_RST = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] OMEGA_KP_RST = GAIN_W'(7680);
    localparam logic [GAIN_W-1:0] OMEGA_KI_RST = GAIN_W'(4480);
    localparam logic [GAIN_W-1:0] OMEGA_KD_RST = GAIN_W'(0);

    // datapath widths
    localparam int ERR_W    = SPEED_W + 1;
    localparam int DELTA_W  = ERR_W + 1;
    localparam int KS_W     = GAIN_W + 1;
    localparam int P_W      = ERR_W + KS_W;
    localparam int I_W      = INTEGRAL_WIDTH + KS_W;
    localparam int D_W      = DELTA_W + KS_W;
    localparam int TERM_W   = TERM_SHIFT + 2;
    localparam int CMP_W    = (I_W > TERM_W) ? I_W : TERM_W;
    localparam int CMD_W    = TERM_W + 1;
    localparam int MIX_W    = CMD_W + 1;
    localparam int TRUNC_W  = MIX_W - FRAC_SHIFT;
    localparam int CLAMP_W  = $clog2(DUTY_LIMIT + 1) + 1;
    localparam int MAG_W    = (CLAMP_W > DUTY_W) ? CLAMP_W : DUTY_W;

    localparam logic signed [INTEGRAL_WIDTH-1:0] INTEG_MAX =
        {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] INTEG_MIN =
        {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } ddpm_gains_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_setpoint;
        logic signed [SPEED_W-1:0] omega_setpoint;
        ddpm_gains_t               speed_gains;
        ddpm_gains_t               omega_gains;
    } ddpm_cfg_t;

    // load strobes of the three loop stages
    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
    } ddpm_stage_en_t;

endpackage

// ===== hw/rtl/ddpm_if.sv =====
// valid/ready channel interfaces for measurement and wheel command transactions
// depends on ddpm_pkg
`timescale 1ns / 1ps

interface ddpm_meas_if
    import ddpm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] measured_omega;

    modport source (output valid, output measured_speed, output measured_omega,
                    input ready);
    modport sink   (input valid, input measured_speed, input measured_omega,
                    output ready);
endinterface

interface ddpm_cmd_if
    import ddpm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] right_duty;
    logic              right_reverse;
    logic [DUTY_W-1:0] left_duty;
    logic              left_reverse;

    modport source (output valid, output right_duty, output right_reverse,
                    output left_duty, output left_reverse, input ready);
    modport sink   (input valid, input right_duty, input right_reverse,
                    input left_duty, input left_reverse, output ready);
endinterface

// ===== hw/rtl/ddpm_regs.sv =====
// apb configuration registers: setpoints and gains of both loops
// depends on ddpm_pkg
`timescale 1ns / 1ps

module ddpm_regs
    import ddpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ddpm_cfg_t         cfg
);

    ddpm_cfg_t         cfg_reg;
    logic [IDX_W-1:0]  idx;
    logic [GAIN_W-1:0] wval;
    logic [GAIN_W-1:0] rval;
    logic              wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wval   = pwdata[GAIN_W-1:0];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_setpoint <= '0;
            cfg_reg.omega_setpoint <= '0;
            cfg_reg.speed_gains    <= '{kp: SPEED_KP_RST, ki: SPEED_KI_RST,
                                        kd: SPEED_KD_RST};
            cfg_reg.omega_gains    <= '{kp: OMEGA_KP_RST, ki: OMEGA_KI_RST,
                                        kd: OMEGA_KD_RST};
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SPEED_SETPOINT: cfg_reg.speed_setpoint <= $signed(wval);
                REG_OMEGA_SETPOINT: cfg_reg.omega_setpoint <= $signed(wval);
                REG_SPEED_KP:       cfg_reg.speed_gains.kp <= wval;
                REG_SPEED_KI:       cfg_reg.speed_gains.ki <= wval;
                REG_SPEED_KD:       cfg_reg.speed_gains.kd <= wval;
                REG_OMEGA_KP:       cfg_reg.omega_gains.kp <= wval;
                REG_OMEGA_KI:       cfg_reg.omega_gains.ki <= wval;
                REG_OMEGA_KD:       cfg_reg.omega_gains.kd <= wval;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SPEED_SETPOINT: rval = cfg_reg.speed_setpoint;
            REG_OMEGA_SETPOINT: rval = cfg_reg.omega_setpoint;
            REG_SPEED_KP:       rval = cfg_reg.speed_gains.kp;
            REG_SPEED_KI:       rval = cfg_reg.speed_gains.ki;
            REG_SPEED_KD:       rval = cfg_reg.speed_gains.kd;
            REG_OMEGA_KP:       rval = cfg_reg.omega_gains.kp;
            REG_OMEGA_KI:       rval = cfg_reg.omega_gains.ki;
            REG_OMEGA_KD:       rval = cfg_reg.omega_gains.kd;
            default:            rval = '0;
        endcase
    end

    assign prdata = {{(DATA_W-GAIN_W){1'b0}}, rval};
    assign cfg    = cfg_reg;

endmodule

// ===== hw/rtl/ddpm_pid.sv =====
// one pid loop in three stages: state update, gain products, term sum
// depends on ddpm_pkg
`timescale 1ns / 1ps

module ddpm_pid
    import ddpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ddpm_stage_en_t            en,
    input  logic signed [SPEED_W-1:0] setpoint,
    input  logic signed [SPEED_W-1:0] measured,
    input  ddpm_gains_t               gains,
    output logic signed [CMD_W-1:0]   loop_cmd
);

    // stage 1: loop state doubles as the stage register
    logic signed [INTEGRAL_WIDTH-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]          last_err_reg, last_err_next;
    logic signed [DELTA_W-1:0]        delta_reg, delta_next;
    logic signed [INTEGRAL_WIDTH:0]   integ_sum;

    // stage 2: products
    logic signed [P_W-1:0] p_reg, p_next;
    logic signed [I_W-1:0] i_reg, i_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic signed [KS_W-1:0] kp_s, ki_s, kd_s;

    // stage 3: loop command
    logic signed [CMD_W-1:0] cmd_reg, cmd_next;
    logic signed [CMP_W-1:0] i_ext, i_sat;
    logic signed [CMP_W-1:0] term_hi, term_lo;

    assign last_err_next = ERR_W'(setpoint) - ERR_W'(measured);
    assign integ_sum     = (INTEGRAL_WIDTH+1)'(integ_reg)
                         + (INTEGRAL_WIDTH+1)'(last_err_next);
    assign delta_next    = DELTA_W'(last_err_next) - DELTA_W'(last_err_reg);

    always_comb
    begin
        priority if (integ_sum[INTEGRAL_WIDTH] == integ_sum[INTEGRAL_WIDTH-1])
            integ_next = integ_sum[INTEGRAL_WIDTH-1:0];
        else if (integ_sum[INTEGRAL_WIDTH])
            integ_next = INTEG_MIN;
        else
            integ_next = INTEG_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else if (en.ld_s1)
        begin
            integ_reg    <= integ_next;
            last_err_reg <= last_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_s1)
            delta_reg <= delta_next;
    end

    assign kp_s   = $signed({1'b0, gains.kp});
    assign ki_s   = $signed({1'b0, gains.ki});
    assign kd_s   = $signed({1'b0, gains.kd});
    assign p_next = last_err_reg * kp_s;
    assign i_next = integ_reg * ki_s;
    assign d_next = delta_reg * kd_s;

    always_ff @(posedge clk)
    begin
        if (en.ld_s2)
        begin
            p_reg <= p_next;
            i_reg <= i_next;
            d_reg <= d_next;
        end
    end

    // integral term bounded to +-2^40
    assign term_hi = CMP_W'(longint'(1) <<< TERM_SHIFT);
    assign term_lo = -term_hi;
    assign i_ext   = CMP_W'(i_reg);

    always_comb
    begin
        priority if (i_ext > term_hi)
            i_sat = term_hi;
        else if (i_ext < term_lo)
            i_sat = term_lo;
        else
            i_sat = i_ext;
    end

    assign cmd_next = CMD_W'(p_reg) + CMD_W'(i_sat) + CMD_W'(d_reg);

    always_ff @(posedge clk)
    begin
        if (en.ld_s3)
            cmd_reg <= cmd_next;
    end

    assign loop_cmd = cmd_reg;

endmodule

// ===== hw/rtl/ddpm_mix.sv =====
// wheel mixer: sum and difference, truncation, clamp, magnitude and direction
// depends on ddpm_pkg; holds the output register
`timescale 1ns / 1ps

module ddpm_mix
    import ddpm_pkg::*;
(
    input  logic                    clk,
    input  logic                    ld,
    input  logic signed [CMD_W-1:0] speed_cmd,
    input  logic signed [CMD_W-1:0] omega_cmd,
    output logic [DUTY_W-1:0]       right_duty,
    output logic                    right_reverse,
    output logic [DUTY_W-1:0]       left_duty,
    output logic                    left_reverse
);

    localparam logic signed [TRUNC_W-1:0] LIM_HI = TRUNC_W'(DUTY_LIMIT);
    localparam logic signed [TRUNC_W-1:0] LIM_LO = -LIM_HI;

    logic signed [MIX_W-1:0]   right_mix, left_mix;
    logic signed [CLAMP_W-1:0] right_c, left_c;
    logic signed [MAG_W-1:0]   right_x, left_x;
    logic [MAG_W-1:0]          right_mag, left_mag;

    logic [DUTY_W-1:0] right_duty_reg, left_duty_reg;
    logic              right_rev_reg, left_rev_reg;

    // q.16 to integer toward zero, then clamp
    function automatic logic signed [CLAMP_W-1:0] to_cmd(
        input logic signed [MIX_W-1:0] q
    );
        logic signed [MIX_W-1:0]   biased;
        logic signed [TRUNC_W-1:0] t;
        logic signed [TRUNC_W-1:0] c;
        biased = q + (q[MIX_W-1] ? MIX_W'({FRAC_SHIFT{1'b1}}) : '0);
        t      = biased[MIX_W-1:FRAC_SHIFT];
        if (t > LIM_HI)
            c = LIM_HI;
        else if (t < LIM_LO)
            c = LIM_LO;
        else
            c = t;
        return c[CLAMP_W-1:0];
    endfunction

    assign right_mix = MIX_W'(speed_cmd) - MIX_W'(omega_cmd);
    assign left_mix  = MIX_W'(speed_cmd) + MIX_W'(omega_cmd);
    assign right_c   = to_cmd(right_mix);
    assign left_c    = to_cmd(left_mix);
    assign right_x   = MAG_W'(right_c);
    assign left_x    = MAG_W'(left_c);
    assign right_mag = right_x[MAG_W-1] ? -right_x : right_x;
    assign left_mag  = left_x[MAG_W-1] ? -left_x : left_x;

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            right_duty_reg <= right_mag[DUTY_W-1:0];
            right_rev_reg  <= right_c[CLAMP_W-1] || (right_c == '0);
            left_duty_reg  <= left_mag[DUTY_W-1:0];
            // left wheel is negated, so it reverses when the sum is not negative
            left_rev_reg   <= !left_c[CLAMP_W-1];
        end
    end

    assign right_duty    = right_duty_reg;
    assign right_reverse = right_rev_reg;
    assign left_duty     = left_duty_reg;
    assign left_reverse  = left_rev_reg;

endmodule

// ===== hw/rtl/differential_drive_pid_mixer_top.sv =====
// top level of the differential drive pid mixer
// depends on ddpm_pkg, ddpm_if, ddpm_regs, ddpm_pid and ddpm_mix
`timescale 1ns / 1ps

// usage
//   meas: one transaction per control tick with measured_speed and
//   measured_omega (signed q7.8). cmd: one transaction per tick with a duty
//   magnitude and reverse bit for each wheel. apb port: setpoints and gains,
//   register i at byte address 4*i, written only while the block is idle.
// path: an accepted measurement passes error and integrator, gain products and
//   term sum, then the mixer into the output register; each step is
//   registered.
// throughput: one transaction per clock while cmd.ready stays high; the limit is
//   the integrator and previous-error update that each tick needs from the last.
// stall: every stage holds while the next one is full and stalled; bubbles
//   still fill, so up to four ticks are in flight before meas.ready drops.
// reset: both integrators and previous errors clear, setpoints go to zero,
//   gains take their defaults and the pipeline empties.
module differential_drive_pid_mixer_top
    import ddpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ddpm_meas_if.sink         meas,
    ddpm_cmd_if.source        cmd,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ddpm_cfg_t      cfg;
    ddpm_stage_en_t en;

    // stage valid flags; s4 is the output register
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [CMD_W-1:0] speed_cmd, omega_cmd;

    ddpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage takes new data when it is empty or its content moves on
    assign rdy4 = !s4_valid_reg || cmd.ready;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign meas.ready = rdy1;

    // loop state advances only on an accepted measurement
    assign en.ld_s1 = meas.valid && rdy1;
    assign en.ld_s2 = s1_valid_reg && rdy2;
    assign en.ld_s3 = s2_valid_reg && rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= meas.valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    ddpm_pid u_speed_pid (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .setpoint (cfg.speed_setpoint),
        .measured (meas.measured_speed),
        .gains    (cfg.speed_gains),
        .loop_cmd (speed_cmd)
    );

    ddpm_pid u_omega_pid (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .setpoint (cfg.omega_setpoint),
        .measured (meas.measured_omega),
        .gains    (cfg.omega_gains),
        .loop_cmd (omega_cmd)
    );

    // mixer writes the output register as the last stage
    ddpm_mix u_mix (
        .clk           (clk),
        .ld            (s3_valid_reg && rdy4),
        .speed_cmd     (speed_cmd),
        .omega_cmd     (omega_cmd),
        .right_duty    (cmd.right_duty),
        .right_reverse (cmd.right_reverse),
        .left_duty     (cmd.left_duty),
        .left_reverse  (cmd.left_reverse)
    );

    assign cmd.valid = s4_valid_reg;

    // an accepted measurement always lands in the first stage
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (meas.valid && meas.ready) |=> s1_valid_reg)
        else $error("accepted measurement lost at first stage");

    // output drains when nothing waits behind it
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && !s3_valid_reg) |=> !cmd.valid)
        else $error("result repeated after drain");

    // a zero duty within an 8-bit limit means a zero command, which reverses
    a_zero_duty_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (DUTY_LIMIT <= 255) && (cmd.right_duty == '0))
        |-> cmd.right_reverse)
        else $error("zero right command without reverse");

endmodule
